// ===== rtl/eeb_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// eeb_pkg
// Shared types and constants of the extended Euclid / Bezout block.
// ----------------------------------------------------------------------------
package eeb_pkg;

  // default operand width
  localparam int OPERAND_BITS_DEF = 31;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STEP,
    ST_DIV,
    ST_FINISH
  } eeb_state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture operands, init recurrences
    logic div_start;  // launch one division step
    logic update;     // shift remainder and coefficient pairs
    logic emit;       // write result register
  } eeb_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic err;        // an operand was zero
    logic r1_zero;    // remainder chain finished
    logic div_done;   // divider result ready
    logic out_free;   // result register can take a beat
  } eeb_sts_t;

endpackage : eeb_pkg
`default_nettype wire

// ===== rtl/eeb_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// eeb_in_if / eeb_out_if
// Valid/ready channels carrying operand beats and result beats.
// ----------------------------------------------------------------------------
interface eeb_in_if
  import eeb_pkg::*;
#(
  parameter int OPERAND_BITS = OPERAND_BITS_DEF
);
  logic                    valid;
  logic                    ready;
  logic [OPERAND_BITS-1:0] operand_a;
  logic [OPERAND_BITS-1:0] operand_b;

  modport source (output valid, output operand_a, output operand_b, input ready);
  modport sink   (input valid, input operand_a, input operand_b, output ready);
endinterface : eeb_in_if

interface eeb_out_if
  import eeb_pkg::*;
#(
  parameter int OPERAND_BITS = OPERAND_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic [OPERAND_BITS-1:0]      common_divisor;
  logic signed [OPERAND_BITS:0] coef_x;
  logic signed [OPERAND_BITS:0] coef_y;
  logic                         status;

  modport source (output valid, output common_divisor, output coef_x, output coef_y,
                  output status, input ready);
  modport sink   (input valid, input common_divisor, input coef_x, input coef_y,
                  input status, output ready);
endinterface : eeb_out_if
`default_nettype wire

// ===== rtl/eeb_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// eeb_div
// Restoring divider, one quotient bit per cycle, MSB first. Each quotient bit
// also feeds two Horner accumulators that form q*mul_s and q*mul_t.
// ----------------------------------------------------------------------------
module eeb_div
  import eeb_pkg::*;
#(
  parameter int OPERAND_BITS = OPERAND_BITS_DEF
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start_i,
  input  wire logic [OPERAND_BITS-1:0] dividend_i,
  input  wire logic [OPERAND_BITS-1:0] divisor_i,
  input  wire logic [OPERAND_BITS:0]   mul_s_i,
  input  wire logic [OPERAND_BITS:0]   mul_t_i,
  output logic                         done_o,
  output logic [OPERAND_BITS-1:0]      rem_o,
  output logic [OPERAND_BITS:0]        prod_s_o,
  output logic [OPERAND_BITS:0]        prod_t_o
);

  localparam int N    = OPERAND_BITS;
  localparam int C    = OPERAND_BITS + 1;
  localparam int CntW = $clog2(N);
  localparam logic [CntW-1:0] LastCnt = CntW'(N - 1);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [N-1:0]    rem_q, rem_d;
  logic [N-1:0]    dvd_q, dvd_d;
  logic [C-1:0]    acc_s_q, acc_s_d;
  logic [C-1:0]    acc_t_q, acc_t_d;

  logic [N:0]      shifted;
  logic [N:0]      diff;
  logic            qbit;

  // no borrow out of the trial subtraction means the divisor fits
  always_comb begin
    shifted = {rem_q, dvd_q[N-1]};
    diff    = shifted - {1'b0, divisor_i};
    qbit    = !diff[N];
  end

  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    dvd_d   = dvd_q;
    acc_s_d = acc_s_q;
    acc_t_d = acc_t_q;
    if (start_i) begin
      busy_d  = 1'b1;
      cnt_d   = LastCnt;
      rem_d   = '0;
      dvd_d   = dividend_i;
      acc_s_d = '0;
      acc_t_d = '0;
    end else if (busy_q) begin
      rem_d   = qbit ? diff[N-1:0] : shifted[N-1:0];
      dvd_d   = {dvd_q[N-2:0], 1'b0};
      acc_s_d = {acc_s_q[C-2:0], 1'b0} + (qbit ? mul_s_i : '0);
      acc_t_d = {acc_t_q[C-2:0], 1'b0} + (qbit ? mul_t_i : '0);
      cnt_d   = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q   <= rem_d;
    dvd_q   <= dvd_d;
    acc_s_q <= acc_s_d;
    acc_t_q <= acc_t_d;
  end

  assign done_o   = done_q;
  assign rem_o    = rem_q;
  assign prod_s_o = acc_s_q;
  assign prod_t_o = acc_t_q;

endmodule : eeb_div
`default_nettype wire

// ===== rtl/eeb_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// eeb_dp
// Remainder and coefficient registers, the shared divider and the result
// register with its valid flag.
// ----------------------------------------------------------------------------
module eeb_dp
  import eeb_pkg::*;
#(
  parameter int OPERAND_BITS = OPERAND_BITS_DEF
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire eeb_cmd_t                cmd_i,
  output eeb_sts_t                     sts_o,
  input  wire logic [OPERAND_BITS-1:0] operand_a_i,
  input  wire logic [OPERAND_BITS-1:0] operand_b_i,
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output logic [OPERAND_BITS-1:0]      common_divisor_o,
  output logic [OPERAND_BITS:0]        coef_x_o,
  output logic [OPERAND_BITS:0]        coef_y_o,
  output logic                         status_o
);

  localparam int N = OPERAND_BITS;
  localparam int C = OPERAND_BITS + 1;
  localparam logic [C-1:0] CoefOne = {{(C-1){1'b0}}, 1'b1};

  logic [N-1:0] r0_q, r1_q;
  logic [C-1:0] s0_q, s1_q, t0_q, t1_q;
  logic         err_q;
  logic         out_valid_q;
  logic [N-1:0] gcd_q;
  logic [C-1:0] cx_q, cy_q;
  logic         status_q;

  logic         div_done;
  logic [N-1:0] div_rem;
  logic [C-1:0] prod_s, prod_t;

  eeb_div #(
    .OPERAND_BITS(OPERAND_BITS)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.div_start),
    .dividend_i(r0_q),
    .divisor_i (r1_q),
    .mul_s_i   (s1_q),
    .mul_t_i   (t1_q),
    .done_o    (div_done),
    .rem_o     (div_rem),
    .prod_s_o  (prod_s),
    .prod_t_o  (prod_t)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      r0_q  <= operand_a_i;
      r1_q  <= operand_b_i;
      s0_q  <= CoefOne;
      s1_q  <= '0;
      t0_q  <= '0;
      t1_q  <= CoefOne;
      err_q <= (operand_a_i == '0) || (operand_b_i == '0);
    end else if (cmd_i.update) begin
      r0_q <= r1_q;
      r1_q <= div_rem;
      s0_q <= s1_q;
      s1_q <= s0_q - prod_s;
      t0_q <= t1_q;
      t1_q <= t0_q - prod_t;
    end
    if (cmd_i.emit) begin
      gcd_q    <= err_q ? '0 : r0_q;
      cx_q     <= err_q ? '0 : s0_q;
      cy_q     <= err_q ? '0 : t0_q;
      status_q <= err_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_comb begin
    sts_o.err      = err_q;
    sts_o.r1_zero  = (r1_q == '0);
    sts_o.div_done = div_done;
    sts_o.out_free = !out_valid_q || out_ready_i;
  end

  assign out_valid_o      = out_valid_q;
  assign common_divisor_o = gcd_q;
  assign coef_x_o         = cx_q;
  assign coef_y_o         = cy_q;
  assign status_o         = status_q;

endmodule : eeb_dp
`default_nettype wire

// ===== rtl/eeb_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// eeb_ctrl
// Sequencer: load, repeated division steps until the remainder is zero or
// an operand was zero, then hand the result to the output register.
// ----------------------------------------------------------------------------
module eeb_ctrl
  import eeb_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire eeb_sts_t sts_i,
  output eeb_cmd_t      cmd_o
);

  eeb_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_STEP;
      end
      ST_STEP: begin
        if (sts_i.err || sts_i.r1_zero) state_d = ST_FINISH;
        else                            state_d = ST_DIV;
      end
      ST_DIV: begin
        if (sts_i.div_done) state_d = ST_STEP;
      end
      ST_FINISH: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_STEP: begin
        cmd_o.div_start = !(sts_i.err || sts_i.r1_zero);
      end
      ST_DIV: begin
        cmd_o.update = sts_i.div_done;
      end
      ST_FINISH: begin
        cmd_o.emit = sts_i.out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  // result only goes out when the output register can take it
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> sts_i.out_free)
    else $error("emit while result register busy");

  // a loaded item always goes to the step check next
  a_load_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> (state_q == ST_STEP))
    else $error("load not followed by step");

  // divider is never restarted or bypassed while a step is in flight
  a_div_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && !sts_i.div_done) |=> (state_q == ST_DIV))
    else $error("left division before divider finished");

  // update only on divider completion
  a_update_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.update |-> (sts_i.div_done && !cmd_o.div_start))
    else $error("update without divider result");

endmodule : eeb_ctrl
`default_nettype wire

// ===== rtl/extended_euclid_bezout_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// extended_euclid_bezout_top
// Extended Euclidean algorithm: gcd and Bezout coefficients of two operands.
// ----------------------------------------------------------------------------
// Takes one beat (operand_a, operand_b) on in_i and returns one beat on out_o
// with g = gcd(a, b) and coefficients x, y such that a*x + b*y = g, in the
// minimal form of the textbook recurrence; if either operand is zero, status
// is 1 and g, x, y are 0. Operands are OPERAND_BITS wide, coefficients are
// OPERAND_BITS+1 bits two's complement. One item is in flight at a time:
// in_i.ready is high only while the sequencer is idle. Each Euclid step runs
// one pass of the shared restoring divider, one quotient bit per cycle, and
// the products q*s and q*t are built in shift-add form from the same bits.
// The number of division steps is 0 for a zero operand and at most about
// 1.44*OPERAND_BITS. The result sits in an output register; the next item
// is accepted while it waits.
// ----------------------------------------------------------------------------
module extended_euclid_bezout_top
  import eeb_pkg::*;
#(
  parameter int OPERAND_BITS = OPERAND_BITS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  eeb_in_if.sink    in_i,
  eeb_out_if.source out_o
);

  eeb_cmd_t                cmd;
  eeb_sts_t                sts;
  logic [OPERAND_BITS:0]   coef_x;
  logic [OPERAND_BITS:0]   coef_y;

  // sequencer: owns in_i.ready and all datapath commands
  eeb_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_i.valid),
    .in_ready_o(in_i.ready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  // remainder/coefficient registers, divider, result register
  eeb_dp #(
    .OPERAND_BITS(OPERAND_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .operand_a_i     (in_i.operand_a),
    .operand_b_i     (in_i.operand_b),
    .out_valid_o     (out_o.valid),
    .out_ready_i     (out_o.ready),
    .common_divisor_o(out_o.common_divisor),
    .coef_x_o        (coef_x),
    .coef_y_o        (coef_y),
    .status_o        (out_o.status)
  );

  assign out_o.coef_x = $signed(coef_x);
  assign out_o.coef_y = $signed(coef_y);

endmodule : extended_euclid_bezout_top
`default_nettype wire
